>>> src/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types and constants of the feature min-max scaler.
// ----------------------------------------------------------------------------
package fsc_pkg;

    localparam int VALUE_BITS  = 16;
    localparam int IDX_BITS    = 10;
    localparam int CFG_BITS    = 11;
    localparam int SCALED_BITS = 17;
    localparam int STATUS_BITS = 2;
    localparam int FRAC_BITS   = 16;
    localparam int CNT_W       = $clog2(FRAC_BITS + 1);

    localparam logic [SCALED_BITS-1:0] SCALE_ONE   = SCALED_BITS'(1 << FRAC_BITS);
    localparam logic [SCALED_BITS-1:0] SCALE_ZERO  = '0;
    localparam logic [VALUE_BITS-1:0]  MOST_POS    = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0]  MOST_NEG    = {1'b1, {(VALUE_BITS-1){1'b0}}};

    localparam logic OP_OBSERVE   = 1'b0;
    localparam logic OP_NORMALIZE = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_BELOW = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_ABOVE = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_BAD   = 2'd3;

    localparam logic                REG_FEATURES_IN_USE = 1'b0;
    localparam logic [CFG_BITS-1:0] FEATURES_IN_USE_RST = 11'd1024;

    typedef struct packed {
        logic                  start;
        logic [FRAC_BITS-1:0]  num;
        logic [FRAC_BITS-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [FRAC_BITS-1:0]  quot;
    } div_rsp_t;

endpackage

>>> src/fsc_div.sv
// ----------------------------------------------------------------------------
// fsc_div
// Radix-2 restoring divider, one fraction bit per cycle, for num < den.
// ----------------------------------------------------------------------------
module fsc_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  fsc_pkg::div_req_t req,
    output fsc_pkg::div_rsp_t rsp
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [fsc_pkg::CNT_W-1:0]      cnt_reg;
    logic [fsc_pkg::FRAC_BITS-1:0]  rem_reg;
    logic [fsc_pkg::FRAC_BITS-1:0]  den_reg;
    logic [fsc_pkg::FRAC_BITS-1:0]  quot_reg;

    logic [fsc_pkg::FRAC_BITS:0]    shifted;
    logic [fsc_pkg::FRAC_BITS:0]    diff;
    logic                           fits;

    // remainder stays below den, so the doubled value fits one extra bit
    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !req.start && (cnt_reg == fsc_pkg::CNT_W'(1));
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= fsc_pkg::CNT_W'(fsc_pkg::FRAC_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == fsc_pkg::CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= req.num;
            den_reg  <= req.den;
            quot_reg <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg  <= diff[fsc_pkg::FRAC_BITS-1:0];
                quot_reg <= {quot_reg[fsc_pkg::FRAC_BITS-2:0], 1'b1};
            end else begin
                rem_reg  <= shifted[fsc_pkg::FRAC_BITS-1:0];
                quot_reg <= {quot_reg[fsc_pkg::FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

>>> src/feature_min_max_scaler.sv
// ----------------------------------------------------------------------------
// feature_min_max_scaler
// Per-feature min-max tracking and normalization to unsigned Q1.16.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ stream: s_tuser is the opcode (observe or
// normalize), s_tdata holds the feature index and a signed Q8.8 sample.
// Every item returns exactly one result item on the m_ stream: the scaled
// value in m_tdata and a status code in m_tuser.
// Items are handled one at a time; s_tready is low while an item is in work.
// A normalize item that reaches the divider passes, from accept to the next
// possible accept, through the accept, the bounds read, the compare, the
// sixteen steps and the done flag of the radix-2 divider, and the hand-off to
// the output register.
// Normalize items that clip or land exactly on one skip the divider, observe
// items and equal bounds skip the compare too, bad indexes also the read.
// The result sits in an output register, so the next item is taken while a
// result waits; a stalled receiver holds the block only once a second result
// is ready.
// After reset a clearing pass loads every feature's bounds (minimum to the
// most positive, maximum to the most negative value); no item is accepted
// during it, configuration writes are taken as usual.
// features_in_use sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module feature_min_max_scaler #(
    parameter int FEATURES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // feature_index [9:0], sample_value [25:10]
    input  logic        s_tuser,   // opcode
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // scaled_value [16:0]
    output logic [1:0]  m_tuser    // status
);

    localparam int VB     = fsc_pkg::VALUE_BITS;
    localparam int ADDR_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FEATURES - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]                      state_reg, state_next;
    logic [ADDR_W-1:0]               clr_reg;
    logic [fsc_pkg::CFG_BITS-1:0]    fiu_reg;

    logic                            op_reg;
    logic [ADDR_W-1:0]               idx_reg;
    logic [VB-1:0]                   val_reg;
    logic signed [VB:0]              num_reg, den_reg;
    logic [fsc_pkg::SCALED_BITS-1:0] res_scaled_reg, res_scaled_next;
    logic [fsc_pkg::STATUS_BITS-1:0] res_status_reg, res_status_next;

    logic                            m_tvalid_reg;
    logic [fsc_pkg::SCALED_BITS-1:0] m_scaled_reg;
    logic [fsc_pkg::STATUS_BITS-1:0] m_status_reg;

    logic [2*VB-1:0]                 mem [FEATURES];
    logic [2*VB-1:0]                 rd_reg;
    logic                            mem_we;
    logic [ADDR_W-1:0]               mem_waddr;
    logic [2*VB-1:0]                 mem_wdata;

    logic [fsc_pkg::IDX_BITS-1:0]    in_idx;
    logic [VB-1:0]                   in_val;
    logic [ADDR_W-1:0]               in_addr;
    logic                            in_bad;
    logic                            s_accept;

    logic signed [VB-1:0]            lo, hi, val_s;
    logic signed [VB:0]              num_raw, den_raw;
    logic signed [VB:0]              num_pos, den_pos;
    logic                            out_free;

    fsc_pkg::div_req_t               div_req;
    fsc_pkg::div_rsp_t               div_rsp;

    fsc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == fsc_pkg::REG_FEATURES_IN_USE)
                    ? {{(32-fsc_pkg::CFG_BITS){1'b0}}, fiu_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fiu_reg <= fsc_pkg::FEATURES_IN_USE_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == fsc_pkg::REG_FEATURES_IN_USE) begin
            fiu_reg <= pwdata[fsc_pkg::CFG_BITS-1:0];
        end
    end

    // input decode
    assign in_idx   = s_tdata[fsc_pkg::IDX_BITS-1:0];
    assign in_val   = s_tdata[fsc_pkg::IDX_BITS +: VB];
    assign in_addr  = ADDR_W'(in_idx);
    assign in_bad   = ({1'b0, in_idx} >= fiu_reg) || (int'(in_idx) >= FEATURES);
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // bounds memory: maximum in the upper half, minimum in the lower half
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[in_addr];
    end

    assign lo    = signed'(rd_reg[VB-1:0]);
    assign hi    = signed'(rd_reg[2*VB-1:VB]);
    assign val_s = signed'(val_reg);

    assign num_raw = (VB+1)'(val_s) - (VB+1)'(lo);
    assign den_raw = (VB+1)'(hi) - (VB+1)'(lo);

    // bounds never observed give a negative span: flip both signs
    assign num_pos = den_reg[VB] ? -num_reg : num_reg;
    assign den_pos = den_reg[VB] ? -den_reg : den_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = {(val_s > hi) ? val_reg : rd_reg[2*VB-1:VB],
                     (val_s < lo) ? val_reg : rd_reg[VB-1:0]};
        if (state_reg == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = {fsc_pkg::MOST_NEG, fsc_pkg::MOST_POS};
        end else if (state_reg == S_LOAD && op_reg == fsc_pkg::OP_OBSERVE) begin
            mem_we = 1'b1;
        end
    end

    always_comb begin
        state_next      = state_reg;
        res_scaled_next = res_scaled_reg;
        res_status_next = res_status_reg;
        div_req.start   = 1'b0;
        div_req.num     = num_pos[VB-1:0];
        div_req.den     = den_pos[VB-1:0];
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    res_scaled_next = fsc_pkg::SCALE_ZERO;
                    if (in_bad) begin
                        res_status_next = fsc_pkg::ST_BAD;
                        state_next      = S_FIN;
                    end else begin
                        res_status_next = fsc_pkg::ST_OK;
                        state_next      = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                if (op_reg == fsc_pkg::OP_OBSERVE || lo == hi) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                priority if (num_pos[VB]) begin
                    res_status_next = fsc_pkg::ST_BELOW;
                    state_next      = S_FIN;
                end else if (num_pos > den_pos) begin
                    res_status_next = fsc_pkg::ST_ABOVE;
                    res_scaled_next = fsc_pkg::SCALE_ONE;
                    state_next      = S_FIN;
                end else if (num_pos == den_pos) begin
                    res_scaled_next = fsc_pkg::SCALE_ONE;
                    state_next      = S_FIN;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    res_scaled_next = {1'b0, div_rsp.quot};
                    state_next      = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == S_FIN && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_scaled_reg <= res_scaled_next;
        res_status_reg <= res_status_next;
        if (s_accept) begin
            op_reg  <= s_tuser;
            idx_reg <= in_addr;
            val_reg <= in_val;
        end
        if (state_reg == S_LOAD) begin
            num_reg <= num_raw;
            den_reg <= den_raw;
        end
        if (state_reg == S_FIN && out_free) begin
            m_scaled_reg <= res_scaled_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(24-fsc_pkg::SCALED_BITS){1'b0}}, m_scaled_reg};
    assign m_tuser  = m_status_reg;

endmodule

>>> src/fsc_checker.sv
// ----------------------------------------------------------------------------
// fsc_checker
// Port-level checks of the feature min-max scaler, bound to the top level.
// ----------------------------------------------------------------------------
module fsc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // one item at a time: ready drops right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // scaled value never above one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[16:0] <= fsc_pkg::SCALE_ONE)
        else $error("scaled value above one");

    // bad index and clipped below give zero, clipped above gives one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == fsc_pkg::ST_BAD || m_tuser == fsc_pkg::ST_BELOW)
        |-> m_tdata == 24'd0)
        else $error("nonzero value with zero status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == fsc_pkg::ST_ABOVE |-> m_tdata[16:0] == fsc_pkg::SCALE_ONE)
        else $error("clipped above without full scale");

endmodule

bind feature_min_max_scaler fsc_checker u_fsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-feature min-max scaler.
// ----------------------------------------------------------------------------
// A table of directed items runs first: never-observed bounds, equal bounds,
// exact zero and one, clipping on both sides and bad indexes under several
// features_in_use settings. Random phases follow, one per register setting,
// with items focused on a small window of features so that observe and
// normalize items meet on the same bounds. Every accepted input item runs
// through a local scaling model; results are checked in order on the m_
// stream while the sender works in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_FEATURES = 1024;
    localparam logic [2:0] ADDR_FIU = {fsc_pkg::REG_FEATURES_IN_USE, 2'b00};

    typedef struct packed {
        logic [fsc_pkg::SCALED_BITS-1:0] scaled;
        logic [fsc_pkg::STATUS_BITS-1:0] status;
    } scaled_res_t;

    typedef struct {
        logic                           is_cfg;
        logic [fsc_pkg::CFG_BITS-1:0]   cfg;
        logic                           op;
        logic [fsc_pkg::IDX_BITS-1:0]   idx;
        logic [fsc_pkg::VALUE_BITS-1:0] val;
        logic                           typed;
        scaled_res_t                    res;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    feature_min_max_scaler #(
        .FEATURES(NUM_FEATURES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // local copy of the bounds and the register
    logic signed [fsc_pkg::VALUE_BITS-1:0] feat_min [NUM_FEATURES];
    logic signed [fsc_pkg::VALUE_BITS-1:0] feat_max [NUM_FEATURES];
    logic [fsc_pkg::CFG_BITS-1:0]          fiu_model;

    scaled_res_t pending_res [$];
    stim_row_t   stim_rows [$];
    int          errors;
    int          burst_left;
    int          hold_req;

    // typed expectation of the item on offer, read by the monitor at accept
    logic        cur_typed;
    scaled_res_t cur_res;

    function automatic scaled_res_t scale_item(logic op, logic [fsc_pkg::IDX_BITS-1:0] idx,
                                               logic signed [fsc_pkg::VALUE_BITS-1:0] val);
        scaled_res_t r;
        longint      lo;
        longint      hi;
        longint      num;
        longint      den;
        int          lim;
        r = '0;
        lim = (fiu_model > NUM_FEATURES) ? NUM_FEATURES : int'(fiu_model);
        if (int'(idx) >= lim) begin
            r.status = fsc_pkg::ST_BAD;
        end else if (op == fsc_pkg::OP_OBSERVE) begin
            if (val < feat_min[idx]) feat_min[idx] = val;
            if (val > feat_max[idx]) feat_max[idx] = val;
        end else begin
            lo = feat_min[idx];
            hi = feat_max[idx];
            if (lo != hi) begin
                num = longint'(val) - lo;
                den = hi - lo;
                // never observed: min above max, flip both signs
                if (den < 0) begin
                    num = -num;
                    den = -den;
                end
                if (num < 0) begin
                    r.status = fsc_pkg::ST_BELOW;
                    r.scaled = fsc_pkg::SCALE_ZERO;
                end else if (num > den) begin
                    r.status = fsc_pkg::ST_ABOVE;
                    r.scaled = fsc_pkg::SCALE_ONE;
                end else begin
                    r.scaled = fsc_pkg::SCALED_BITS'((num * 65536) / den);
                end
            end
        end
        return r;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // monitor: checks results, then predicts newly accepted items
    always @(posedge aclk) begin
        scaled_res_t want;
        scaled_res_t got;
        if (aresetn) begin
            if (psel && penable && pwrite && pready && paddr == ADDR_FIU)
                fiu_model = pwdata[fsc_pkg::CFG_BITS-1:0];
            if (m_tvalid && m_tready) begin
                got.scaled = m_tdata[fsc_pkg::SCALED_BITS-1:0];
                got.status = m_tuser;
                if (pending_res.size() == 0) begin
                    $display("%0t: result item with none expected, scaled %0d status %0d",
                             $time, got.scaled, got.status);
                    errors++;
                end else begin
                    want = pending_res.pop_front();
                    if (got.scaled !== want.scaled) begin
                        $display("%0t: scaled_value expected %0d, got %0d",
                                 $time, want.scaled, got.scaled);
                        errors++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, got.status);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want = scale_item(s_tuser, s_tdata[fsc_pkg::IDX_BITS-1:0],
                                  s_tdata[fsc_pkg::IDX_BITS +: fsc_pkg::VALUE_BITS]);
                pending_res.push_back(cur_typed ? cur_res : want);
            end
        end
    end

    // receiver: segments of random stall patterns, plus a long hold on request
    initial begin
        int seg;
        int mode;
        int hold_cnt;
        int hold_seen;
        seg = 0;
        mode = 0;
        hold_cnt = 0;
        hold_seen = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready = 1'b0;
            end else begin
                if (seg == 0) begin
                    seg = $urandom_range(20, 200);
                    mode = $urandom_range(0, 3);
                end
                seg--;
                case (mode)
                    0: m_tready = 1'b1;
                    1: m_tready = ($urandom_range(0, 3) != 0);
                    2: m_tready = ($urandom_range(0, 3) == 0);
                    default: m_tready = ~m_tready;
                endcase
            end
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // called at a falling edge, returns at a falling edge after the accept
    task automatic send_item(logic op, logic [fsc_pkg::IDX_BITS-1:0] idx,
                             logic [fsc_pkg::VALUE_BITS-1:0] val,
                             logic typed, scaled_res_t res);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        cur_typed = typed;
        cur_res = res;
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {{(32-fsc_pkg::IDX_BITS-fsc_pkg::VALUE_BITS){1'b0}}, val, idx};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
    endtask

    // stop offering and wait until every expected result has arrived
    task automatic drain();
        s_tvalid = 1'b0;
        burst_left = 0;
        while (pending_res.size() != 0) @(negedge aclk);
    endtask

    task automatic add_item(logic op, logic [fsc_pkg::IDX_BITS-1:0] idx,
                            logic [fsc_pkg::VALUE_BITS-1:0] val,
                            logic typed, logic [fsc_pkg::SCALED_BITS-1:0] scaled,
                            logic [fsc_pkg::STATUS_BITS-1:0] status);
        stim_row_t r;
        r.is_cfg = 1'b0;
        r.cfg = '0;
        r.op = op;
        r.idx = idx;
        r.val = val;
        r.typed = typed;
        r.res.scaled = scaled;
        r.res.status = status;
        stim_rows.push_back(r);
    endtask

    task automatic add_cfg(logic [fsc_pkg::CFG_BITS-1:0] value);
        stim_row_t r;
        r.is_cfg = 1'b1;
        r.cfg = value;
        r.op = fsc_pkg::OP_OBSERVE;
        r.idx = '0;
        r.val = '0;
        r.typed = 1'b0;
        r.res = '0;
        stim_rows.push_back(r);
    endtask

    initial begin
        int phase_fiu [9];
        int n_items;
        int lim;
        int base;
        logic op;
        logic [fsc_pkg::IDX_BITS-1:0] idx;
        logic [fsc_pkg::VALUE_BITS-1:0] val;

        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cur_typed = 1'b0;
        cur_res = '0;
        errors = 0;
        burst_left = 0;
        hold_req = 0;
        for (int i = 0; i < NUM_FEATURES; i++) begin
            feat_min[i] = fsc_pkg::MOST_POS;
            feat_max[i] = fsc_pkg::MOST_NEG;
        end
        fiu_model = fsc_pkg::FEATURES_IN_USE_RST;

        // never-observed bounds
        add_item(fsc_pkg::OP_NORMALIZE, 10'd0, fsc_pkg::MOST_POS, 1'b1,
                 fsc_pkg::SCALE_ZERO, fsc_pkg::ST_OK);
        add_item(fsc_pkg::OP_NORMALIZE, 10'd0, fsc_pkg::MOST_NEG, 1'b1,
                 fsc_pkg::SCALE_ONE, fsc_pkg::ST_OK);
        add_item(fsc_pkg::OP_NORMALIZE, 10'd1, 16'h0000, 1'b0, '0, fsc_pkg::ST_OK);
        // full range on the top index
        add_item(fsc_pkg::OP_OBSERVE, 10'd1023, fsc_pkg::MOST_POS, 1'b1,
                 fsc_pkg::SCALE_ZERO, fsc_pkg::ST_OK);
        add_item(fsc_pkg::OP_OBSERVE, 10'd1023, fsc_pkg::MOST_NEG, 1'b1,
                 fsc_pkg::SCALE_ZERO, fsc_pkg::ST_OK);
        add_item(fsc_pkg::OP_NORMALIZE, 10'd1023, fsc_pkg::MOST_POS, 1'b1,
                 fsc_pkg::SCALE_ONE, fsc_pkg::ST_OK);
        add_item(fsc_pkg::OP_NORMALIZE, 10'd1023, fsc_pkg::MOST_NEG, 1'b1,
                 fsc_pkg::SCALE_ZERO, fsc_pkg::ST_OK);
        add_item(fsc_pkg::OP_NORMALIZE, 10'd1023, 16'h0000, 1'b0, '0, fsc_pkg::ST_OK);
        // equal bounds, then clipping on both sides
        add_item(fsc_pkg::OP_OBSERVE, 10'd5, 16'd100, 1'b1,
                 fsc_pkg::SCALE_ZERO, fsc_pkg::ST_OK);
        add_item(fsc_pkg::OP_NORMALIZE, 10'd5, 16'd100, 1'b1,
                 fsc_pkg::SCALE_ZERO, fsc_pkg::ST_OK);
        add_item(fsc_pkg::OP_NORMALIZE, 10'd5, -16'sd5, 1'b1,
                 fsc_pkg::SCALE_ZERO, fsc_pkg::ST_OK);
        add_item(fsc_pkg::OP_OBSERVE, 10'd5, 16'd356, 1'b1,
                 fsc_pkg::SCALE_ZERO, fsc_pkg::ST_OK);
        add_item(fsc_pkg::OP_NORMALIZE, 10'd5, 16'd228, 1'b0, '0, fsc_pkg::ST_OK);
        add_item(fsc_pkg::OP_NORMALIZE, 10'd5, 16'd99, 1'b1,
                 fsc_pkg::SCALE_ZERO, fsc_pkg::ST_BELOW);
        add_item(fsc_pkg::OP_NORMALIZE, 10'd5, 16'd357, 1'b1,
                 fsc_pkg::SCALE_ONE, fsc_pkg::ST_ABOVE);
        add_item(fsc_pkg::OP_NORMALIZE, 10'd5, 16'd356, 1'b1,
                 fsc_pkg::SCALE_ONE, fsc_pkg::ST_OK);
        add_item(fsc_pkg::OP_NORMALIZE, 10'd5, 16'd100, 1'b1,
                 fsc_pkg::SCALE_ZERO, fsc_pkg::ST_OK);
        // bad index for both opcodes, state left alone
        add_cfg(11'd6);
        add_item(fsc_pkg::OP_OBSERVE, 10'd6, 16'd50, 1'b1,
                 fsc_pkg::SCALE_ZERO, fsc_pkg::ST_BAD);
        add_item(fsc_pkg::OP_NORMALIZE, 10'd1023, 16'h0000, 1'b1,
                 fsc_pkg::SCALE_ZERO, fsc_pkg::ST_BAD);
        add_item(fsc_pkg::OP_NORMALIZE, 10'd5, 16'd228, 1'b0, '0, fsc_pkg::ST_OK);
        add_item(fsc_pkg::OP_OBSERVE, 10'd5, -16'sd200, 1'b1,
                 fsc_pkg::SCALE_ZERO, fsc_pkg::ST_OK);
        add_cfg(11'd0);
        add_item(fsc_pkg::OP_NORMALIZE, 10'd0, 16'd7, 1'b1,
                 fsc_pkg::SCALE_ZERO, fsc_pkg::ST_BAD);
        // register above the feature count is limited by it
        add_cfg(11'h7FF);
        add_item(fsc_pkg::OP_NORMALIZE, 10'd1023, 16'h0000, 1'b0, '0, fsc_pkg::ST_OK);
        add_item(fsc_pkg::OP_OBSERVE, 10'd6, 16'd1, 1'b1,
                 fsc_pkg::SCALE_ZERO, fsc_pkg::ST_OK);
        add_cfg(11'd1024);
        add_item(fsc_pkg::OP_NORMALIZE, 10'd6, 16'h0100, 1'b0, '0, fsc_pkg::ST_OK);

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_cfg) begin
                drain();
                apb_write(ADDR_FIU, 32'(stim_rows[i].cfg));
            end else begin
                send_item(stim_rows[i].op, stim_rows[i].idx, stim_rows[i].val,
                          stim_rows[i].typed, stim_rows[i].res);
            end
        end
        cur_typed = 1'b0;

        phase_fiu = '{1024, 1, 37, 1023, 8, 0, 2047, 0, 1024};
        phase_fiu[7] = $urandom_range(1, 1024);
        foreach (phase_fiu[p]) begin
            drain();
            apb_write(ADDR_FIU, 32'(phase_fiu[p]));
            lim = (phase_fiu[p] > NUM_FEATURES) ? NUM_FEATURES : phase_fiu[p];
            n_items = (lim == 0) ? 30 : 120;
            base = (lim == 0) ? 0 : $urandom_range(0, lim - 1);
            for (int k = 0; k < n_items; k++) begin
                if (p == 3 && k == 10) hold_req++;
                if (k % 40 == 39 && lim > 0) base = $urandom_range(0, lim - 1);
                op = ($urandom_range(0, 9) < 4) ? fsc_pkg::OP_OBSERVE : fsc_pkg::OP_NORMALIZE;
                case ($urandom_range(0, 9))
                    0: idx = fsc_pkg::IDX_BITS'($urandom);
                    1: idx = (lim < NUM_FEATURES) ?
                             fsc_pkg::IDX_BITS'($urandom_range(lim, NUM_FEATURES - 1)) :
                             fsc_pkg::IDX_BITS'($urandom);
                    default: begin
                        idx = fsc_pkg::IDX_BITS'(base + $urandom_range(0, 7));
                        if (int'(idx) >= lim && lim > 0)
                            idx = fsc_pkg::IDX_BITS'($urandom_range(0, lim - 1));
                    end
                endcase
                case ($urandom_range(0, 9))
                    0: val = fsc_pkg::MOST_POS;
                    1: val = fsc_pkg::MOST_NEG;
                    2: val = '0;
                    3, 4, 5: val = fsc_pkg::VALUE_BITS'($urandom);
                    default: val = fsc_pkg::VALUE_BITS'($urandom_range(0, 4000) - 2000);
                endcase
                send_item(op, idx, val, 1'b0, '0);
            end
        end

        drain();
        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
